// ===== rtl/pcx_rle_encoder_defines.svh =====
// Assertion macros for the PCX run-length encoder checker.
// Used by the checker only; expects clk and rst_n in scope.
`ifndef PCX_RLE_ENCODER_DEFINES_SVH
`define PCX_RLE_ENCODER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define PCXE_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcx_rle_encoder: implication check failed");

// Next-cycle implication, off during reset.
`define PCXE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcx_rle_encoder: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define PCXE_ASSERT_NEXT_ALWAYS(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pcx_rle_encoder: reset check failed");

`endif

// ===== rtl/pcxe_pkg.sv =====
// Package for the PCX run-length encoder: command type and constants.
// No dependencies.
`timescale 1ns / 1ps

package pcxe_pkg;

  localparam logic [5:0]  MAX_RUN       = 6'd63;
  localparam logic [7:0]  CNT_BASE      = 8'hC0;
  localparam logic [15:0] WIDTH_RESET   = 16'd320;
  localparam logic [15:0] HEIGHT_RESET  = 16'd200;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Mask bit positions, in emit order.
  localparam int M_CNT1 = 0;
  localparam int M_VAL1 = 1;
  localparam int M_CNT2 = 2;
  localparam int M_VAL2 = 3;
  localparam int M_PAD  = 4;
  localparam int M_EOI  = 5;

  typedef struct packed {
    logic [5:0] mask;
    logic [7:0] val1;
    logic [5:0] len1;
    logic [7:0] val2;
    logic [5:0] len2;
  } pcxe_cmd_t;

endpackage

// ===== rtl/pcxe_front.sv =====
// Front end: config registers, run tracking, row/image position.
// Turns each accepted pixel into at most one byte-emit command. Depends on pcxe_pkg.
`timescale 1ns / 1ps

module pcxe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  input  logic [7:0]        in_pixel,
  input  logic              q_full,
  output logic              in_stall,
  output logic              push,
  output pcxe_pkg::pcxe_cmd_t cmd
);
  import pcxe_pkg::*;

  logic [15:0] width_r, height_r;
  logic [7:0]  run_val_r, run_val_nxt;
  logic [5:0]  run_len_r, run_len_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;

  logic [15:0] w_eff, h_eff, col_inc, row_inc;
  logic        accept, cont, row_end, img_end, c1_en;
  logic [7:0]  new_val;
  logic [5:0]  new_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    w_eff   = (width_r == 16'd0) ? 16'd1 : width_r;
    h_eff   = (height_r == 16'd0) ? 16'd1 : height_r;
    cont    = (run_len_r != 6'd0) && (in_pixel == run_val_r) && (run_len_r < MAX_RUN);
    new_val = cont ? run_val_r : in_pixel;
    new_len = cont ? run_len_r + 6'd1 : 6'd1;
    col_inc = col_r + 16'd1;
    row_inc = row_r + 16'd1;
    row_end = col_inc >= w_eff;
    img_end = row_end && (row_inc >= h_eff);
    c1_en   = !cont && (run_len_r != 6'd0);

    cmd.val1 = run_val_r;
    cmd.len1 = run_len_r;
    cmd.val2 = new_val;
    cmd.len2 = new_len;
    cmd.mask[M_CNT1] = c1_en && ((run_len_r > 6'd1) || (run_val_r[7:6] != 2'b00));
    cmd.mask[M_VAL1] = c1_en;
    cmd.mask[M_CNT2] = row_end && ((new_len > 6'd1) || (new_val[7:6] != 2'b00));
    cmd.mask[M_VAL2] = row_end;
    cmd.mask[M_PAD]  = row_end && w_eff[0];
    cmd.mask[M_EOI]  = img_end;

    push = accept && (cmd.mask != 6'd0);

    run_val_nxt = run_val_r;
    run_len_nxt = run_len_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    if (accept) begin
      run_val_nxt = new_val;
      run_len_nxt = row_end ? 6'd0 : new_len;
      col_nxt     = row_end ? 16'd0 : col_inc;
      row_nxt     = row_end ? (img_end ? 16'd0 : row_inc) : row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_val_r <= 8'd0;
      run_len_r <= 6'd0;
      col_r     <= 16'd0;
      row_r     <= 16'd0;
    end else begin
      run_val_r <= run_val_nxt;
      run_len_r <= run_len_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
    end
  end

endmodule

// ===== rtl/pcxe_queue.sv =====
// Small command FIFO between the front end and the byte emitter.
// Depends on pcxe_pkg.
`timescale 1ns / 1ps

module pcxe_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pcxe_pkg::pcxe_cmd_t wr_cmd,
  input  logic                pop,
  output pcxe_pkg::pcxe_cmd_t rd_cmd,
  output logic                full,
  output logic                empty
);
  import pcxe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  pcxe_cmd_t     slot_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + PW'(1);
    if (do_pop)  rp_nxt = (rp_r == PTR_LAST) ? '0 : rp_r + PW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/pcxe_back.sv =====
// Back end: expands one command into its bytes, one per cycle
// unless stalled, into a registered output stage. Depends on pcxe_pkg.
`timescale 1ns / 1ps

module pcxe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pcxe_pkg::pcxe_cmd_t head,
  input  logic                q_empty,
  output logic                pop,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [7:0]          out_code_byte,
  output logic                out_last,
  output logic                out_end_of_image
);
  import pcxe_pkg::*;

  pcxe_cmd_t  cmd_r;
  logic [5:0] mask_r, mask_nxt, lowest, rem;
  logic       busy, emit, load;
  logic       ov_r, ov_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, eoi_r, eoi_nxt;

  always_comb begin
    busy   = (mask_r != 6'd0);
    emit   = busy && (!ov_r || !out_stall);
    lowest = mask_r & (~mask_r + 6'd1);
    rem    = mask_r & ~lowest;
    load   = !busy || (emit && (rem == 6'd0));
    pop    = load && !q_empty;

    if (pop)       mask_nxt = head.mask;
    else if (emit) mask_nxt = rem;
    else           mask_nxt = mask_r;

    eoi_nxt = 1'b0;
    if (mask_r[M_CNT1])      byte_nxt = CNT_BASE | {2'b00, cmd_r.len1};
    else if (mask_r[M_VAL1]) byte_nxt = cmd_r.val1;
    else if (mask_r[M_CNT2]) byte_nxt = CNT_BASE | {2'b00, cmd_r.len2};
    else if (mask_r[M_VAL2]) byte_nxt = cmd_r.val2;
    else if (mask_r[M_PAD])  byte_nxt = 8'd0;
    else begin
      byte_nxt = 8'd0;
      eoi_nxt  = 1'b1;
    end

    ov_nxt = emit ? 1'b1 : (out_stall ? ov_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 6'd0;
      ov_r   <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cmd_r <= head;
    if (emit) begin
      byte_r <= byte_nxt;
      last_r <= (rem == 6'd0);
      eoi_r  <= eoi_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_code_byte    = byte_r;
  assign out_last         = last_r;
  assign out_end_of_image = eoi_r;

endmodule

// ===== rtl/pcx_rle_encoder.sv =====
// PCX run-length encoder top level, 8 bits per pixel.
// Instantiates pcxe_front, pcxe_queue and pcxe_back; depends on pcxe_pkg.
//
// Input channel: in_valid/in_stall with in_pixel, pixels in raster order.
// Output channel: out_valid/out_stall with out_code_byte, out_last (last
// byte caused by a pixel) and out_end_of_image (terminating zero byte).
// A transaction completes at a rising edge with valid high and stall low.
// Configuration: cfg_we writes cfg_data to image_width (index 0) or
// image_height (index 1); write only while the block is idle.
// A pixel's first byte goes through the command queue and the emitter's
// command register into the output register. The emitter sends one byte
// per cycle while the output is not stalled; a pixel causes 0 to 6 bytes.
// The front takes one pixel per cycle while the command queue (QUEUE_DEPTH
// entries) has room. Pixels that only extend a run cause no bytes.
// Reset (rst_n low, synchronous) clears runs, position and queue, sets the
// registers to 320 x 200, and drops out_valid.
// A stalled output holds its byte; the queue then fills and in_stall rises.
`timescale 1ns / 1ps

module pcx_rle_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_code_byte,
  output logic        out_last,
  output logic        out_end_of_image
);
  import pcxe_pkg::*;

  pcxe_cmd_t wr_cmd, rd_cmd;
  logic      push, pop, q_full, q_empty;

  pcxe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_pixel (in_pixel),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .cmd      (wr_cmd)
  );

  pcxe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wr_cmd(wr_cmd),
    .pop   (pop),
    .rd_cmd(rd_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  pcxe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (rd_cmd),
    .q_empty         (q_empty),
    .pop             (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_code_byte   (out_code_byte),
    .out_last        (out_last),
    .out_end_of_image(out_end_of_image)
  );

endmodule

// ===== rtl/pcxe_checker.sv =====
// Port-level checker for pcx_rle_encoder, bound to the top level.
// Depends on pcx_rle_encoder_defines.svh.
`timescale 1ns / 1ps
`include "pcx_rle_encoder_defines.svh"

module pcxe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_code_byte,
  input logic       out_last,
  input logic       out_end_of_image
);

  `PCXE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_code_byte) && $stable(out_last) && $stable(out_end_of_image))

  `PCXE_ASSERT_IMPLY(a_eoi_last, out_valid && out_end_of_image, out_last)

  `PCXE_ASSERT_IMPLY(a_eoi_zero, out_valid && out_end_of_image, out_code_byte == 8'd0)

  `PCXE_ASSERT_NEXT_ALWAYS(a_reset_idle, !rst_n, !out_valid)

endmodule

bind pcx_rle_encoder pcxe_checker u_pcxe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_code_byte   (out_code_byte),
  .out_last        (out_last),
  .out_end_of_image(out_end_of_image)
);
